// ----- hdl/ray_box_slab_intersection_defines.svh -----
// Assertion macros for the ray/box slab test.
// They expect clk and rst_n in the scope where they are used.
`ifndef RAY_BOX_SLAB_INTERSECTION_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECTION_DEFINES_SVH

// same-cycle implication, off during reset
`define RBSI_ASSERT_IMPLY(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rbsi: same-cycle check failed");

// next-cycle implication, off during reset
`define RBSI_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rbsi: next-cycle check failed");

`endif

// ----- hdl/rbsi_pkg.sv -----
`default_nettype none

package rbsi_pkg;

    localparam int DEF_COORD_BITS = 32;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int AXES           = 3;
    localparam int FIELD_COUNT    = 4 * AXES;
    localparam int ENTRY_BITS     = 31;
    localparam int OUT_TDATA_BITS = ((1 + ENTRY_BITS + 7) / 8) * 8;

    // field slots inside the input word, counted in coordinates
    localparam int SLOT_ORIGIN  = 0;
    localparam int SLOT_DIR     = AXES;
    localparam int SLOT_BOX_MIN = 2 * AXES;
    localparam int SLOT_BOX_MAX = 3 * AXES;

    typedef struct packed {
        logic [ENTRY_BITS-1:0] entry_distance;
        logic                  hit;
    } rbsi_result_t;

endpackage

`default_nettype wire

// ----- hdl/rbsi_slab_div.sv -----
`default_nettype none

// Pipelined slab quotient: (num << FRAC_BITS) / den, one quotient bit per stage,
// rounded toward +inf and saturated to +/-TLIM.
module rbsi_slab_div
    import rbsi_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         ce,
    input  wire logic [COORD_BITS:0]          num_mag,
    input  wire logic [COORD_BITS-1:0]        den_mag,
    input  wire logic                         neg,
    output logic signed [COORD_BITS-1:0]      t
);

    localparam int NUM_W = COORD_BITS + 1 + FRAC_BITS;
    localparam int DW    = (NUM_W > 2 * COORD_BITS - 1) ? NUM_W : 2 * COORD_BITS - 1;
    localparam int QB    = COORD_BITS - 1;
    localparam logic signed [COORD_BITS-1:0] TLIM = {1'b0, {QB{1'b1}}};

    logic [DW-1:0]         rem_reg [QB+1];
    logic [COORD_BITS-1:0] den_reg [QB+1];
    logic [QB-1:0]         q_reg   [QB+1];
    logic                  ovf_reg [QB+1];
    logic                  neg_reg [QB+1];

    logic [DW-1:0] un;
    logic [DW-1:0] dtop;

    always_comb
    begin
        un   = DW'(num_mag) << FRAC_BITS;
        dtop = DW'(den_mag) << QB;
    end

    // quotient too big for QB bits means saturation
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0] <= un;
            den_reg[0] <= den_mag;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (un >= dtop);
            neg_reg[0] <= neg;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int SH = QB - 1 - j;
        logic [DW-1:0] trial;
        logic          take;
        logic [QB-1:0] q_next;

        always_comb
        begin
            trial      = DW'(den_reg[j]) << SH;
            take       = (rem_reg[j] >= trial);
            q_next     = q_reg[j];
            q_next[SH] = take;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[j+1] <= take ? (rem_reg[j] - trial) : rem_reg[j];
                den_reg[j+1] <= den_reg[j];
                q_reg[j+1]   <= q_next;
                ovf_reg[j+1] <= ovf_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    logic [QB:0]                  up;
    logic signed [COORD_BITS-1:0] t_next;
    logic signed [COORD_BITS-1:0] t_reg;

    always_comb
    begin
        up = {1'b0, q_reg[QB]} + {{QB{1'b0}}, (rem_reg[QB] != '0)};
        priority if (ovf_reg[QB])
            t_next = neg_reg[QB] ? -TLIM : TLIM;
        else if (neg_reg[QB])
            t_next = -$signed({1'b0, q_reg[QB]});
        else if (up[QB])
            t_next = TLIM;
        else
            t_next = $signed(up);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            t_reg <= t_next;
        end
    end

    assign t = t_reg;

endmodule

`default_nettype wire

// ----- hdl/rbsi_clamp.sv -----
`default_nettype none

// Running tmin/tmax clamp, one axis per stage in x, y, z order.
module rbsi_clamp
    import rbsi_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                ce,
    input  wire logic [2*AXES*COORD_BITS-1:0]        t_all,    // per axis: t at box_min, t at box_max
    input  wire logic [AXES-1:0]                     dzero_at, // bit a: item entering stage a
    output logic signed [COORD_BITS-1:0]             tmin,
    output logic signed [COORD_BITS-1:0]             tmax
);

    localparam int TW = 2 * AXES * COORD_BITS;
    localparam logic signed [COORD_BITS-1:0] TLIM = {1'b0, {(COORD_BITS-1){1'b1}}};

    logic signed [COORD_BITS-1:0] tmin_reg [AXES];
    logic signed [COORD_BITS-1:0] tmax_reg [AXES];
    logic [TW-1:0]                tc_reg   [AXES];

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        logic signed [COORD_BITS-1:0] tmin_in, tmax_in, t1, t2, lo, hi, m1, m2;
        logic signed [COORD_BITS-1:0] nmin, nmax;
        logic [TW-1:0]                tin;

        if (a == 0) begin : g_first
            assign tmin_in = '0;
            assign tmax_in = TLIM;
            assign tin     = t_all;
        end else begin : g_next
            assign tmin_in = tmin_reg[a-1];
            assign tmax_in = tmax_reg[a-1];
            assign tin     = tc_reg[a-1];
        end

        always_comb
        begin
            t1 = $signed(tin[2*a*COORD_BITS +: COORD_BITS]);
            t2 = $signed(tin[(2*a+1)*COORD_BITS +: COORD_BITS]);
            lo = (t1 < t2) ? t1 : t2;
            hi = (t1 < t2) ? t2 : t1;
            // entry first, exit then sees the new entry
            m1 = (tmax_in < lo) ? tmax_in : lo;
            nmin = (tmin_in < m1) ? m1 : tmin_in;
            m2 = (hi < nmin) ? nmin : hi;
            nmax = (tmax_in < m2) ? tmax_in : m2;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                tmin_reg[a] <= dzero_at[a] ? tmin_in : nmin;
                tmax_reg[a] <= dzero_at[a] ? tmax_in : nmax;
                tc_reg[a]   <= tin;
            end
        end
    end

    assign tmin = tmin_reg[AXES-1];
    assign tmax = tmax_reg[AXES-1];

endmodule

`default_nettype wire

// ----- hdl/rbsi_entry_check.sv -----
`default_nettype none

// Entry point test: registered d*tmin, then p = o + floor(prod / 2^F) against the box.
module rbsi_entry_check
    import rbsi_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             ce,
    input  wire logic [FIELD_COUNT*COORD_BITS-1:0] query,
    input  wire logic [AXES-1:0]                  zmiss,
    input  wire logic signed [COORD_BITS-1:0]     tmin,
    input  wire logic signed [COORD_BITS-1:0]     tmax,
    output rbsi_result_t                          result
);

    localparam int PW = 2 * COORD_BITS + 1;

    logic signed [2*COORD_BITS-1:0] prod_reg [AXES];
    logic signed [COORD_BITS-1:0]   o_reg    [AXES];
    logic signed [COORD_BITS-1:0]   bl_reg   [AXES];
    logic signed [COORD_BITS-1:0]   bh_reg   [AXES];
    logic signed [COORD_BITS-1:0]   tmin_reg;
    logic                           miss_reg;

    logic signed [COORD_BITS-1:0]   d_s [AXES];
    logic signed [PW-1:0]           p   [AXES];
    logic                           in_box;
    logic                           hit;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            d_s[a] = $signed(query[(SLOT_DIR + a)*COORD_BITS +: COORD_BITS]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                prod_reg[a] <= d_s[a] * tmin;
                o_reg[a]    <= $signed(query[(SLOT_ORIGIN + a)*COORD_BITS +: COORD_BITS]);
                bl_reg[a]   <= $signed(query[(SLOT_BOX_MIN + a)*COORD_BITS +: COORD_BITS]);
                bh_reg[a]   <= $signed(query[(SLOT_BOX_MAX + a)*COORD_BITS +: COORD_BITS]);
            end
            tmin_reg <= tmin;
            miss_reg <= (|zmiss) || (tmin > tmax);
        end
    end

    always_comb
    begin
        in_box = 1'b1;
        for (int a = 0; a < AXES; a++)
        begin
            p[a] = PW'(o_reg[a]) + PW'(prod_reg[a] >>> FRAC_BITS);
            if ((p[a] < PW'(bl_reg[a])) || (p[a] > PW'(bh_reg[a])))
            begin
                in_box = 1'b0;
            end
        end
        hit = !miss_reg && in_box;
        result.hit = hit;
        result.entry_distance = hit ? ENTRY_BITS'($unsigned(tmin_reg)) : '0;
    end

endmodule

`default_nettype wire

// ----- hdl/rbsi_out_buf.sv -----
`default_nettype none

// Output register plus one skid entry; the pipeline runs while the skid is empty.
module rbsi_out_buf
    import rbsi_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire rbsi_result_t  din,
    output logic               ce,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rbsi_result_t       m_data
);

    rbsi_result_t out_reg, out_next, skid_reg, skid_next;
    logic         out_v_reg, out_v_next, skid_v_reg, skid_v_next;
    logic         pop;

    always_comb
    begin
        pop         = out_v_reg && m_ready;
        out_next    = out_reg;
        skid_next   = skid_reg;
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        if (skid_v_reg)
        begin
            if (pop)
            begin
                out_next    = skid_reg;
                skid_v_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_v_reg || pop)
            begin
                out_next   = din;
                out_v_next = 1'b1;
            end
            else
            begin
                skid_next   = din;
                skid_v_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign ce      = !skid_v_reg;
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ----- hdl/ray_box_slab_intersection.sv -----
`default_nettype none

// Ray versus axis-aligned box slab test, fully pipelined. Each input word carries a
// ray origin, a ray direction and the box's lower and upper corners, all signed fixed
// point with FRAC_BITS fraction bits in COORD_BITS bits. Each output word says whether
// the forward ray (t >= 0) hits the box and gives the entry distance tmin in the same
// format (zero on a miss). A new word is taken every clock cycle unless the pipeline
// is stalled. The six slab dividers resolve one quotient bit per stage (COORD_BITS - 1
// restoring steps plus setup and rounding). A zero direction on an axis leaves
// tmin/tmax alone when the origin is inside that slab and forces a miss otherwise.
// Quotients round toward +inf and saturate at +/-(2^(COORD_BITS-1) - 1). Backpressure
// stalls the whole pipeline; a skid entry behind the output register keeps s_axis_tready
// a registered signal, so a finished word waiting downstream does not block the next
// input. The block holds no state between words.
module ray_box_slab_intersection
    import rbsi_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_min_x, box_min_y,
    // box_min_z, box_max_x, box_max_y, box_max_z; zero padded to whole bytes
    input  wire logic [((FIELD_COUNT*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // hit, entry_distance[30:0]
    output logic [OUT_TDATA_BITS-1:0]   m_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready
);

    localparam int IN_BITS    = FIELD_COUNT * COORD_BITS;
    localparam int QW         = IN_BITS + 2 * AXES;     // query plus dzero, zmiss flags
    localparam int DIV_STAGES = COORD_BITS + 1;
    localparam int S_DIV0     = 2;
    localparam int S_CLAMP0   = S_DIV0 + DIV_STAGES;
    localparam int S_PROD     = S_CLAMP0 + AXES;
    localparam int NDIV       = 2 * AXES;

    logic         ce;
    logic [S_PROD:0] v_reg;
    logic [QW-1:0]   qc_reg [S_PROD];

    // stage 1 operands for the dividers
    logic [COORD_BITS:0]   nmag_reg [NDIV];
    logic                  nneg_reg [NDIV];
    logic [COORD_BITS-1:0] dmag_reg [AXES];

    logic signed [COORD_BITS-1:0] o_s  [AXES];
    logic signed [COORD_BITS-1:0] d_s  [AXES];
    logic signed [COORD_BITS-1:0] bl_s [AXES];
    logic signed [COORD_BITS-1:0] bh_s [AXES];
    logic signed [COORD_BITS:0]   diff [NDIV];
    logic [COORD_BITS:0]          nmag [NDIV];
    logic                         nneg [NDIV];
    logic [COORD_BITS-1:0]        dmag [AXES];
    logic [AXES-1:0]              dzero, zmiss;

    assign s_axis_tready = ce;

    // valid bits ride along with the data; everything moves on ce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ce)
        begin
            v_reg <= {v_reg[S_PROD-1:0], s_axis_tvalid};
        end
    end

    // slab differences, magnitudes and sign of each quotient
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            o_s[a]  = $signed(qc_reg[0][(SLOT_ORIGIN + a)*COORD_BITS +: COORD_BITS]);
            d_s[a]  = $signed(qc_reg[0][(SLOT_DIR + a)*COORD_BITS +: COORD_BITS]);
            bl_s[a] = $signed(qc_reg[0][(SLOT_BOX_MIN + a)*COORD_BITS +: COORD_BITS]);
            bh_s[a] = $signed(qc_reg[0][(SLOT_BOX_MAX + a)*COORD_BITS +: COORD_BITS]);
            diff[2*a]   = (COORD_BITS+1)'(bl_s[a]) - (COORD_BITS+1)'(o_s[a]);
            diff[2*a+1] = (COORD_BITS+1)'(bh_s[a]) - (COORD_BITS+1)'(o_s[a]);
            dmag[a]  = d_s[a][COORD_BITS-1] ? $unsigned(-d_s[a]) : $unsigned(d_s[a]);
            dzero[a] = (d_s[a] == '0);
            zmiss[a] = dzero[a] && ((o_s[a] < bl_s[a]) || (o_s[a] > bh_s[a]));
        end
        for (int i = 0; i < NDIV; i++)
        begin
            nmag[i] = diff[i][COORD_BITS] ? $unsigned(-diff[i]) : $unsigned(diff[i]);
            nneg[i] = (diff[i][COORD_BITS] != d_s[i/2][COORD_BITS-1]) && (diff[i] != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            qc_reg[0] <= {{(2*AXES){1'b0}}, s_axis_tdata[IN_BITS-1:0]};
            qc_reg[1] <= {zmiss, dzero, qc_reg[0][IN_BITS-1:0]};
            for (int k = 2; k < S_PROD; k++)
            begin
                qc_reg[k] <= qc_reg[k-1];
            end
            for (int i = 0; i < NDIV; i++)
            begin
                nmag_reg[i] <= nmag[i];
                nneg_reg[i] <= nneg[i];
            end
            for (int a = 0; a < AXES; a++)
            begin
                dmag_reg[a] <= dmag[a];
            end
        end
    end

    logic [NDIV*COORD_BITS-1:0] t_all;

    for (genvar i = 0; i < NDIV; i++) begin : g_div
        logic signed [COORD_BITS-1:0] t_q;

        rbsi_slab_div #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_div (
            .clk     (clk),
            .ce      (ce),
            .num_mag (nmag_reg[i]),
            .den_mag (dmag_reg[i/2]),
            .neg     (nneg_reg[i]),
            .t       (t_q)
        );

        assign t_all[i*COORD_BITS +: COORD_BITS] = t_q;
    end

    logic [AXES-1:0]              dzero_at;
    logic signed [COORD_BITS-1:0] tmin, tmax;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            dzero_at[a] = qc_reg[S_CLAMP0 - 1 + a][IN_BITS + a];
        end
    end

    rbsi_clamp #(
        .COORD_BITS (COORD_BITS)
    ) u_clamp (
        .clk      (clk),
        .ce       (ce),
        .t_all    (t_all),
        .dzero_at (dzero_at),
        .tmin     (tmin),
        .tmax     (tmax)
    );

    rbsi_result_t result, m_word;

    rbsi_entry_check #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_entry (
        .clk    (clk),
        .ce     (ce),
        .query  (qc_reg[S_PROD-1][IN_BITS-1:0]),
        .zmiss  (qc_reg[S_PROD-1][IN_BITS + AXES +: AXES]),
        .tmin   (tmin),
        .tmax   (tmax),
        .result (result)
    );

    rbsi_out_buf u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (ce && v_reg[S_PROD]),
        .din     (result),
        .ce      (ce),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_word)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'(m_word);

endmodule

`default_nettype wire

// ----- hdl/rbsi_checker.sv -----
`default_nettype none

`include "ray_box_slab_intersection_defines.svh"

module rbsi_assertions
    import rbsi_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tready,
    input  wire logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    input  wire logic                      m_axis_tvalid,
    input  wire logic                      m_axis_tready
);

    // a miss never reports a distance
    `RBSI_ASSERT_IMPLY(a_miss_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[OUT_TDATA_BITS-1:1] == '0)
    // empty output means the skid is empty too
    `RBSI_ASSERT_IMPLY(a_ready_when_drained, !m_axis_tvalid, s_axis_tready)
    // input stalls only after a word was held back
    `RBSI_ASSERT_IMPLY(a_stall_cause, $fell(s_axis_tready), $past(m_axis_tvalid && !m_axis_tready))
    // stalled word holds
    `RBSI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind ray_box_slab_intersection rbsi_assertions u_rbsi_assertions (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire
